// ----- hdl/buffered_uart_fifo_pair_core_assert.svh -----
// assertion macros for the buffered uart fifo pair core
`ifndef BUFFERED_UART_FIFO_PAIR_CORE_ASSERT_SVH
`define BUFFERED_UART_FIFO_PAIR_CORE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define BUFU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define BUFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/bufu_pkg.sv -----
// shared codes and types for the buffered uart fifo pair core
package bufu_pkg;

    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;
    localparam int BYTE_W = 8;

    localparam logic [ACT_W-1:0] ACT_PUT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_GET   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RECV  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_THRE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FLUSH = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_TX_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RX_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RX_DROP  = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              rd_valid;
        logic              tx_valid;
        logic              tx_from_mem;
        logic [BYTE_W-1:0] tx_byte;
    } pend_t;

endpackage

// ----- hdl/bufu_ram.sv -----
// generic single write port, single read port ram with registered read
module bufu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/buffered_uart_fifo_pair_core.sv -----
// buffered uart fifo pair: transmit and receive ring queues in front of a uart
//
// input channel s_*: one item per host access or uart event. s_tuser holds the
// action (put, get, receive event, transmit-empty event, flush); s_tdata holds
// the byte and the two uart flags sampled with it.
// result channel m_*: exactly one result item per input item, carrying the
// action's outcome plus queue levels, data-present, room and irq-enable flags.
// each queue lives in its own ram with a registered read. an item is taken
// in the idle cycle, where fill counts and pointers are updated and the ram
// is written or read; the result state then builds the result from the ram
// read data into the output register once that register is free. a new item
// is taken only after the previous result has entered the output register.
// s_tready is high only in the idle cycle. if m_tready stays low the finished
// result holds in the output register and the core waits with its next result
// until the register frees; no item is lost or repeated.
// reset (aresetn low at a clock edge) empties both queues and clears the irq
// enable; no clearing pass runs, the ram contents are left as they are.
module buffered_uart_fifo_pair_core #(
    parameter int TX_DEPTH = 64,
    parameter int RX_DEPTH = 128
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                s_tvalid,
    output logic                                                s_tready,
    // data_byte[7:0], holding_empty[8], rx_data_ready[9]
    input  logic [15:0]                                         s_tdata,
    // action[2:0]
    input  logic [bufu_pkg::ACT_W-1:0]                          s_tuser,
    output logic                                                m_tvalid,
    input  logic                                                m_tready,
    // status, read_byte, read_valid, tx_byte, tx_valid, tx_irq_enable,
    // rx_nonempty, tx_has_room, rx_level, tx_level, then zero fill
    output logic [((23 + $clog2(RX_DEPTH + 1) + $clog2(TX_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                                                m_tdata
);

    localparam int TXA      = $clog2(TX_DEPTH);
    localparam int RXA      = $clog2(RX_DEPTH);
    localparam int TXL      = $clog2(TX_DEPTH + 1);
    localparam int RXL      = $clog2(RX_DEPTH + 1);
    localparam int OUT_BITS = 23 + RXL + TXL;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_RESULT = 1'b1;

    logic                        state_reg, state_next;
    logic [TXA-1:0]              tx_rd_ptr_reg, tx_rd_ptr_next;
    logic [TXA-1:0]              tx_wr_ptr_reg, tx_wr_ptr_next;
    logic [TXL-1:0]              tx_fill_reg, tx_fill_next;
    logic [RXA-1:0]              rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [RXA-1:0]              rx_wr_ptr_reg, rx_wr_ptr_next;
    logic [RXL-1:0]              rx_fill_reg, rx_fill_next;
    logic                        irq_reg, irq_next;
    bufu_pkg::pend_t             pend_reg, pend_next;
    logic                        out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]            out_data_reg, out_data_next;

    logic                        s_accept;
    logic [bufu_pkg::ACT_W-1:0]  action;
    logic [bufu_pkg::BYTE_W-1:0] data_byte;
    logic                        holding_empty;
    logic                        rx_data_ready;
    logic                        tx_full;
    logic                        rx_full;
    logic                        tx_we, tx_re, rx_we, rx_re;
    logic [bufu_pkg::BYTE_W-1:0] tx_rdata, rx_rdata;
    logic [bufu_pkg::BYTE_W-1:0] read_byte;
    logic [bufu_pkg::BYTE_W-1:0] tx_byte;
    logic [OUT_BITS-1:0]         result_bits;

    assign action        = s_tuser;
    assign data_byte     = s_tdata[7:0];
    assign holding_empty = s_tdata[8];
    assign rx_data_ready = s_tdata[9];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign tx_full  = (tx_fill_reg == TXL'(TX_DEPTH));
    assign rx_full  = (rx_fill_reg == RXL'(RX_DEPTH));

    bufu_ram #(
        .WIDTH(bufu_pkg::BYTE_W),
        .DEPTH(TX_DEPTH)
    ) u_tx_ram (
        .aclk (aclk),
        .we   (tx_we),
        .waddr(tx_wr_ptr_reg),
        .wdata(data_byte),
        .re   (tx_re),
        .raddr(tx_rd_ptr_reg),
        .rdata(tx_rdata)
    );

    bufu_ram #(
        .WIDTH(bufu_pkg::BYTE_W),
        .DEPTH(RX_DEPTH)
    ) u_rx_ram (
        .aclk (aclk),
        .we   (rx_we),
        .waddr(rx_wr_ptr_reg),
        .wdata(data_byte),
        .re   (rx_re),
        .raddr(rx_rd_ptr_reg),
        .rdata(rx_rdata)
    );

    assign read_byte = pend_reg.rd_valid ? rx_rdata : '0;
    assign tx_byte   = pend_reg.tx_from_mem ? tx_rdata : pend_reg.tx_byte;

    assign result_bits = {tx_fill_reg, rx_fill_reg, !tx_full, (rx_fill_reg != '0), irq_reg,
                          pend_reg.tx_valid, tx_byte, pend_reg.rd_valid, read_byte,
                          pend_reg.status};

    always_comb begin
        state_next     = state_reg;
        tx_rd_ptr_next = tx_rd_ptr_reg;
        tx_wr_ptr_next = tx_wr_ptr_reg;
        tx_fill_next   = tx_fill_reg;
        rx_rd_ptr_next = rx_rd_ptr_reg;
        rx_wr_ptr_next = rx_wr_ptr_reg;
        rx_fill_next   = rx_fill_reg;
        irq_next       = irq_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        tx_we          = 1'b0;
        tx_re          = 1'b0;
        rx_we          = 1'b0;
        rx_re          = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_RESULT;
                    pend_next  = '0;
                    case (action)
                        bufu_pkg::ACT_PUT: begin
                            if (tx_full) begin
                                pend_next.status = bufu_pkg::STAT_TX_FULL;
                            end else if (tx_fill_reg == '0 && holding_empty) begin
                                pend_next.tx_valid = 1'b1;
                                pend_next.tx_byte  = data_byte;
                            end else begin
                                tx_we          = 1'b1;
                                tx_wr_ptr_next = (tx_wr_ptr_reg == TXA'(TX_DEPTH - 1)) ?
                                                 '0 : tx_wr_ptr_reg + TXA'(1);
                                tx_fill_next   = tx_fill_reg + TXL'(1);
                                irq_next       = 1'b1;
                            end
                        end
                        bufu_pkg::ACT_GET: begin
                            if (rx_fill_reg == '0) begin
                                pend_next.status = bufu_pkg::STAT_RX_EMPTY;
                            end else begin
                                rx_re              = 1'b1;
                                pend_next.rd_valid = 1'b1;
                                rx_rd_ptr_next     = (rx_rd_ptr_reg == RXA'(RX_DEPTH - 1)) ?
                                                     '0 : rx_rd_ptr_reg + RXA'(1);
                                rx_fill_next       = rx_fill_reg - RXL'(1);
                            end
                        end
                        bufu_pkg::ACT_RECV: begin
                            if (rx_data_ready) begin
                                if (rx_full) begin
                                    pend_next.status = bufu_pkg::STAT_RX_DROP;
                                end else begin
                                    rx_we          = 1'b1;
                                    rx_wr_ptr_next = (rx_wr_ptr_reg == RXA'(RX_DEPTH - 1)) ?
                                                     '0 : rx_wr_ptr_reg + RXA'(1);
                                    rx_fill_next   = rx_fill_reg + RXL'(1);
                                end
                            end
                        end
                        bufu_pkg::ACT_THRE: begin
                            if (tx_fill_reg != '0) begin
                                tx_re                 = 1'b1;
                                pend_next.tx_valid    = 1'b1;
                                pend_next.tx_from_mem = 1'b1;
                                tx_rd_ptr_next        = (tx_rd_ptr_reg == TXA'(TX_DEPTH - 1)) ?
                                                        '0 : tx_rd_ptr_reg + TXA'(1);
                                tx_fill_next          = tx_fill_reg - TXL'(1);
                            end else begin
                                irq_next = 1'b0;
                            end
                        end
                        bufu_pkg::ACT_FLUSH: begin
                            tx_rd_ptr_next = '0;
                            tx_wr_ptr_next = '0;
                            tx_fill_next   = '0;
                            rx_rd_ptr_next = '0;
                            rx_wr_ptr_next = '0;
                            rx_fill_next   = '0;
                            irq_next       = 1'b0;
                        end
                        default: begin
                            pend_next.status = bufu_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            S_RESULT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'(result_bits);
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            tx_rd_ptr_reg <= '0;
            tx_wr_ptr_reg <= '0;
            tx_fill_reg   <= '0;
            rx_rd_ptr_reg <= '0;
            rx_wr_ptr_reg <= '0;
            rx_fill_reg   <= '0;
            irq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tx_rd_ptr_reg <= tx_rd_ptr_next;
            tx_wr_ptr_reg <= tx_wr_ptr_next;
            tx_fill_reg   <= tx_fill_next;
            rx_rd_ptr_reg <= rx_rd_ptr_next;
            rx_wr_ptr_reg <= rx_wr_ptr_next;
            rx_fill_reg   <= rx_fill_next;
            irq_reg       <= irq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg     <= pend_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`include "buffered_uart_fifo_pair_core_assert.svh"

    `BUFU_ASSERT_NOW(a_tx_fill_bound, 1'b1, tx_fill_reg <= TXL'(TX_DEPTH), "tx fill above depth")
    `BUFU_ASSERT_NOW(a_rx_fill_bound, 1'b1, rx_fill_reg <= RXL'(RX_DEPTH), "rx fill above depth")
    `BUFU_ASSERT_NOW(a_irq_on_queued, tx_fill_reg != '0, irq_reg, "tx bytes queued with irq off")
    `BUFU_ASSERT_NOW(a_one_ram_read, 1'b1, !(tx_re && rx_re), "both queue rams read at once")
    `BUFU_ASSERT_NEXT(a_result_follows, s_accept, state_reg == S_RESULT, "accept without result")

endmodule
